@@ src/cwa_pkg.sv @@
// ============================================================================
// cwa_pkg: shared types and constants of the centered window average filter
// Holds field widths, the controller state type and the command and status
// bundles that pass between the controller and the datapath.
// ============================================================================
`default_nettype none

package cwa_pkg;

    localparam int DATA_W         = 8;   // sample and result width
    localparam int WIN_W          = 6;   // window length register width
    localparam int MAX_WINDOW_DEF = 32;  // default largest window

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_PASS,
        S_RD_C,
        S_RD_P,
        S_RD_M,
        S_RD_X,
        S_WAIT,
        S_DLOAD,
        S_DIV,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;       // input transfer: store sample, update frame state
        logic start_out;     // set the first output offset
        logic rd_center;     // read the center sample, clear the accumulator
        logic rd_plus;       // read the sample at offset + d
        logic rd_minus;      // read the sample at offset - d, advance d
        logic rd_extra;      // read the newest sample once more
        logic div_load;      // load the divider from the accumulator
        logic div_step;      // one restoring division step
        logic out_load_pass; // load the output register with the raw sample
        logic out_load_avg;  // load the output register with the quotient
        logic next_off;      // move to the next (newer) flush offset
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pass;          // window below two: pass-through
        logic have_out;      // at least one output follows this sample
        logic dmax_ge1;      // at least one symmetric pair is inside the frame
        logic d_last;        // current pair is the last one
        logic extra;         // odd window and offset equals half-width
        logic div_done;      // quotient is ready
        logic out_free;      // output register can take a new result
        logic more;          // further flush outputs remain
    } t_status;

endpackage : cwa_pkg

`default_nettype wire

@@ src/centered_window_average_filter_core.sv @@
// ============================================================================
// centered_window_average_filter_core: centered moving average over frames
// Top level: joins the sequencing controller and the datapath.
// ============================================================================
// The block smooths frames of 8-bit samples. Each input transfer carries one
// sample and, on tlast, the end of its frame. With a half-width h taken from
// the window length (clamped to MAX_WINDOW), output i is the truncated
// average of sample i and every symmetric pair around it that lies wholly in
// the frame; an odd window adds sample i+h once more when output i is the one
// just completed. Output i leaves once sample i+h has arrived, and the last
// sample of a frame flushes all remaining outputs, the final one marked with
// tlast. A window length below two passes samples through unchanged. The
// window length must be written through i_cfg_we / i_cfg_wdata only while the
// block is idle; the user must ensure this, as the block does not enforce it.
// It resets to one. The block works on one input transfer at a time: each
// sample passes through the transfer and the decision, then each output walks
// the window one sample read per cycle from a circular sample RAM and runs a
// restoring divider of SUM_W bits, 14 for the default MAX_WINDOW of 32, that
// yields one quotient bit per cycle. Each output reads its center sample,
// its pairs inside the frame (at most h) and, for an odd window, the extra
// sample. The result sits in an output register, so the next sample is taken
// while the previous result still waits on the output side.
// ============================================================================
`default_nettype none

module centered_window_average_filter_core
    import cwa_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Configuration: window length, written whenever i_cfg_we is high.
    input  wire logic              i_cfg_we,
    input  wire logic [WIN_W-1:0]  i_cfg_wdata,
    // Input stream.
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [DATA_W-1:0] i_s_tdata,   // [7:0] sample
    input  wire logic              i_s_tlast,   // frame end
    // Output stream.
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [DATA_W-1:0]      o_m_tdata,   // [7:0] smoothed
    output logic                   o_m_tlast    // run end
);

    t_cmd    cmd;
    t_status status;

    // The controller owns the handshake on the input side and sequences
    // every read, division step and output load.
    cwa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath holds the sample RAM, the frame position, the accumulator,
    // the divider and the output register.
    cwa_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (i_s_tdata),
        .i_frame_end (i_s_tlast),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule : centered_window_average_filter_core

`default_nettype wire

@@ src/cwa_ram.sv @@
// ============================================================================
// cwa_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module cwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 33
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : cwa_ram

`default_nettype wire

@@ src/cwa_datapath.sv @@
// ============================================================================
// cwa_datapath: sample store, accumulator, divider and output register
// Keeps the frame position, walks the window under controller command,
// divides the sum by the count and holds the result for the output side.
// ============================================================================
`default_nettype none

module cwa_datapath
    import cwa_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [WIN_W-1:0]  i_cfg_wdata,
    input  wire logic [DATA_W-1:0] i_sample,
    input  wire logic              i_frame_end,
    input  wire t_cmd              i_cmd,
    output t_status                o_status,
    input  wire logic              i_m_tready,
    output logic                   o_m_tvalid,
    output logic [DATA_W-1:0]      o_m_tdata,
    output logic                   o_m_tlast
);

    localparam int DEPTH  = MAX_WINDOW + 1;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int H_W    = $clog2(MAX_WINDOW / 2 + 1);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 3);
    localparam int SUM_W  = CNT_W + DATA_W;
    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam int CMP_W  = WIN_W + 2;

    localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CW-1:0]    CNT_SAT   = CW'(DEPTH);
    localparam logic [H_W-1:0]   H_MAX     = H_W'(MAX_WINDOW / 2);
    localparam logic             ODD_MAX   = 1'(MAX_WINDOW % 2);
    localparam logic [CMP_W-1:0] WIN_MAX   = CMP_W'(MAX_WINDOW);
    localparam logic [STEP_W-1:0] STEPS    = STEP_W'(SUM_W);

    logic [WIN_W-1:0]  r_window;
    logic [AW-1:0]     r_head;
    logic [CW-1:0]     r_count;
    logic [AW-1:0]     r_j;
    logic [H_W-1:0]    r_h;
    logic              r_odd;
    logic              r_pass;
    logic              r_last;
    logic [DATA_W-1:0] r_sample;
    logic [AW-1:0]     r_off;
    logic [AW-1:0]     r_d;
    logic              r_rd_v;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_step;
    logic              r_out_v;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_last;

    logic [AW-1:0]     n_head;
    logic [CW-1:0]     cnt_inc;
    logic [AW-1:0]     h_ext;
    logic [AW-1:0]     rd_ofs;
    logic [AW:0]       addr_tmp;
    logic [AW-1:0]     raddr;
    logic [DATA_W-1:0] rdata;
    logic [AW-1:0]     past;
    logic [AW-1:0]     dmax;
    logic [CNT_W:0]    div_trial;
    logic [CNT_W:0]    div_diff;

    assign n_head  = (r_head == LAST_ADDR) ? '0 : r_head + AW'(1);
    assign cnt_inc = (r_count < CNT_SAT) ? r_count + CW'(1) : r_count;
    assign h_ext   = AW'(r_h);

    // Offset behind the newest sample that is read in this cycle.
    always_comb begin
        rd_ofs = r_off;
        if (i_cmd.rd_plus) begin
            rd_ofs = r_off + r_d;
        end else if (i_cmd.rd_minus) begin
            rd_ofs = r_off - r_d;
        end else if (i_cmd.rd_extra) begin
            rd_ofs = '0;
        end
    end

    // Circular buffer: offset k lives k places behind the head.
    assign addr_tmp = {1'b0, r_head} + ((r_head < rd_ofs) ? (AW + 1)'(DEPTH) : '0)
                      - {1'b0, rd_ofs};
    assign raddr    = addr_tmp[AW-1:0];

    cwa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_in),
        .i_waddr (n_head),
        .i_wdata (i_sample),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Pairs are inside the frame up to the smaller of the distances to either end.
    assign past = r_j - r_off;
    assign dmax = (past < r_off) ? past : r_off;

    assign div_trial = {r_rem, r_quo[SUM_W-1]};
    assign div_diff  = div_trial - {1'b0, r_cnt};

    always_comb begin
        o_status.pass     = r_pass;
        o_status.have_out = r_last || (r_j >= h_ext);
        o_status.dmax_ge1 = (dmax != '0);
        o_status.d_last   = (r_d == dmax);
        o_status.extra    = r_odd && (r_off == h_ext);
        o_status.div_done = (r_step == STEPS);
        o_status.out_free = !r_out_v || i_m_tready;
        o_status.more     = r_last && (r_off != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WIN_W'(1);
            r_head   <= '0;
            r_count  <= '0;
            r_rd_v   <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (i_cmd.load_in) begin
                r_head  <= n_head;
                r_count <= i_frame_end ? '0 : cnt_inc;
            end
            r_rd_v <= i_cmd.rd_center | i_cmd.rd_plus | i_cmd.rd_minus | i_cmd.rd_extra;
            if (i_cmd.out_load_pass || i_cmd.out_load_avg) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sample <= i_sample;
            r_last   <= i_frame_end;
            r_j      <= AW'(cnt_inc - CW'(1));
            r_pass   <= (r_window < WIN_W'(2));
            if ({2'b00, r_window} > WIN_MAX) begin
                r_h   <= H_MAX;
                r_odd <= ODD_MAX;
            end else begin
                r_h   <= H_W'(r_window >> 1);
                r_odd <= r_window[0];
            end
        end
        if (i_cmd.start_out) begin
            r_off <= (r_j >= h_ext) ? h_ext : r_j;
        end else if (i_cmd.next_off) begin
            r_off <= r_off - AW'(1);
        end
        if (i_cmd.rd_center) begin
            r_d   <= AW'(1);
            r_sum <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.rd_minus) begin
                r_d <= r_d + AW'(1);
            end
            if (r_rd_v) begin
                r_sum <= r_sum + SUM_W'(rdata);
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
        if (i_cmd.div_load) begin
            r_quo  <= r_sum;
            r_rem  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_step <= r_step + STEP_W'(1);
            if (!div_diff[CNT_W]) begin
                r_rem <= div_diff[CNT_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= div_trial[CNT_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b0};
            end
        end
        if (i_cmd.out_load_pass) begin
            r_out_data <= r_sample;
            r_out_last <= r_last;
        end else if (i_cmd.out_load_avg) begin
            r_out_data <= r_quo[DATA_W-1:0];
            r_out_last <= r_last && (r_off == '0);
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule : cwa_datapath

`default_nettype wire

@@ src/cwa_ctrl.sv @@
// ============================================================================
// cwa_ctrl: sequencing state machine of the centered window average filter
// Takes one input transfer at a time and steps the datapath through the
// window reads, the division and the result hand-off of each output.
// ============================================================================
`default_nettype none

module cwa_ctrl
    import cwa_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // No transfer is taken while reset is held.
                o_s_tready    = i_rst_n;
                o_cmd.load_in = i_s_tvalid && i_rst_n;
                if (i_s_tvalid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.pass) begin
                    n_state = S_PASS;
                end else if (i_status.have_out) begin
                    o_cmd.start_out = 1'b1;
                    n_state         = S_RD_C;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PASS: begin
                if (i_status.out_free) begin
                    o_cmd.out_load_pass = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            S_RD_C: begin
                o_cmd.rd_center = 1'b1;
                if (i_status.dmax_ge1) begin
                    n_state = S_RD_P;
                end else if (i_status.extra) begin
                    n_state = S_RD_X;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_RD_P: begin
                o_cmd.rd_plus = 1'b1;
                n_state       = S_RD_M;
            end
            S_RD_M: begin
                o_cmd.rd_minus = 1'b1;
                if (!i_status.d_last) begin
                    n_state = S_RD_P;
                end else if (i_status.extra) begin
                    n_state = S_RD_X;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_RD_X: begin
                o_cmd.rd_extra = 1'b1;
                n_state        = S_WAIT;
            end
            S_WAIT: begin
                n_state = S_DLOAD;
            end
            S_DLOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load_avg = 1'b1;
                    if (i_status.more) begin
                        o_cmd.next_off = 1'b1;
                        n_state        = S_RD_C;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule : cwa_ctrl

`default_nettype wire
